// ----- hw/rtl/pvfc_pkg.sv -----
// ----------------------------------------------------------------------------
// pvfc_pkg: shared types and codes for the pulsed valve flow controller
// Holds the transaction payloads, the register file, the state record and
// the operation, mode and register index codes.
// ----------------------------------------------------------------------------
package pvfc_pkg;

  localparam int FlowW  = 16;
  localparam int PosW   = 8;
  localparam int OpW    = 3;
  localparam int ModeW  = 3;
  localparam int CntW   = 8;
  localparam int CfgIdxW  = 8;
  localparam int CfgDataW = 16;

  // Operation codes
  localparam logic [OpW-1:0] OP_TICK  = 3'd0;
  localparam logic [OpW-1:0] OP_OPEN  = 3'd1;
  localparam logic [OpW-1:0] OP_CLOSE = 3'd2;
  localparam logic [OpW-1:0] OP_IDLE  = 3'd3;
  localparam logic [OpW-1:0] OP_ERROR = 3'd4;

  // Valve modes
  localparam logic [ModeW-1:0] MODE_IDLE    = 3'd0;
  localparam logic [ModeW-1:0] MODE_OPENING = 3'd1;
  localparam logic [ModeW-1:0] MODE_CLOSING = 3'd2;
  localparam logic [ModeW-1:0] MODE_PCLOSE  = 3'd3;
  localparam logic [ModeW-1:0] MODE_POPEN   = 3'd4;
  localparam logic [ModeW-1:0] MODE_SET     = 3'd5;
  localparam logic [ModeW-1:0] MODE_ERROR   = 3'd6;

  // Register indexes
  localparam logic [CfgIdxW-1:0] REG_FLOW_SETPOINT = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_CLOSED_LEVEL  = 8'd1;
  localparam logic [CfgIdxW-1:0] REG_FULL_LEVEL    = 8'd2;
  localparam logic [CfgIdxW-1:0] REG_PULSE_LENGTH  = 8'd3;

  // Register reset values
  localparam logic [FlowW-1:0] SETPOINT_RST     = 16'd0;
  localparam logic [PosW-1:0]  CLOSED_LEVEL_RST = 8'd12;
  localparam logic [PosW-1:0]  FULL_LEVEL_RST   = 8'd243;
  localparam logic [CntW-1:0]  PULSE_LEN_RST    = 8'd6;

  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [FlowW-1:0] measured_flow;
    logic [PosW-1:0]  valve_position;
  } in_item_t;

  typedef struct packed {
    logic [FlowW-1:0] flow_setpoint;
    logic [PosW-1:0]  closed_level;
    logic [PosW-1:0]  full_level;
    logic [CntW-1:0]  pulse_length;
  } cfg_t;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [CntW-1:0]  pulse_counter;
    logic             open_drive;
    logic             close_drive;
  } valve_state_t;

endpackage

// ----- hw/rtl/pvfc_in_if.sv -----
// ----------------------------------------------------------------------------
// pvfc_in_if: input item channel
// Carries one operation with its flow and position reading.
// ----------------------------------------------------------------------------
interface pvfc_in_if;
  import pvfc_pkg::*;

  logic             valid;
  logic             ready;
  logic [OpW-1:0]   op;
  logic [FlowW-1:0] measured_flow;
  logic [PosW-1:0]  valve_position;

  modport source (output valid, output op, output measured_flow,
                  output valve_position, input ready);
  modport sink   (input valid, input op, input measured_flow,
                  input valve_position, output ready);
endinterface

// ----- hw/rtl/pvfc_out_if.sv -----
// ----------------------------------------------------------------------------
// pvfc_out_if: result channel
// Carries the valve mode and the two drive outputs after each item.
// ----------------------------------------------------------------------------
interface pvfc_out_if;
  import pvfc_pkg::*;

  logic             valid;
  logic             ready;
  logic [ModeW-1:0] valve_mode;
  logic             drive_open;
  logic             drive_close;

  modport source (output valid, output valve_mode, output drive_open,
                  output drive_close, input ready);
  modport sink   (input valid, input valve_mode, input drive_open,
                  input drive_close, output ready);
endinterface

// ----- hw/rtl/pvfc_cfg_if.sv -----
// ----------------------------------------------------------------------------
// pvfc_cfg_if: configuration write channel
// Carries a register index and the data written to it.
// ----------------------------------------------------------------------------
interface pvfc_cfg_if;
  import pvfc_pkg::*;

  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/pulsed_valve_flow_controller.sv -----
// ----------------------------------------------------------------------------
// pulsed_valve_flow_controller: valve state machine with setpoint pulses
// Input register, next-state logic and a result register with backpressure.
// ----------------------------------------------------------------------------
// Usage:
//   in_item  - one transaction per command or 10 ms tick (op, flow, position).
//   out_item - one transaction per input: mode and drive outputs after it.
//   cfg      - register writes (setpoint, closed level, full level, pulse
//              length); take them only while no item is in flight.
// Path: an item is first held in the input register and is then written into
//   the result register when that register can advance.
// Throughput: one item per cycle while out_item.ready is high; the state
//   update sits between the input register and the result register, so each
//   item sees the state left by the one before it.
// Reset: rst (synchronous) empties both stages, returns the valve to idle
//   with both drives off and the pulse counter at zero, and loads the
//   register defaults (setpoint 0, closed 12, full 243, pulse length 6).
// Stall: while out_item.ready is low the result holds; one more item is
//   taken into the input register, then in_item.ready drops.
// ----------------------------------------------------------------------------
module pulsed_valve_flow_controller (
  input logic clk,
  input logic rst,
  pvfc_in_if.sink    in_item,
  pvfc_out_if.source out_item,
  pvfc_cfg_if.sink   cfg
);
  import pvfc_pkg::*;

  cfg_t         regs;
  in_item_t     s1_item;
  logic         s1_valid;
  valve_state_t state;
  valve_state_t state_next;
  logic         out_valid;
  logic         advance;
  logic         s1_move;

  // Configuration writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.flow_setpoint <= SETPOINT_RST;
      regs.closed_level  <= CLOSED_LEVEL_RST;
      regs.full_level    <= FULL_LEVEL_RST;
      regs.pulse_length  <= PULSE_LEN_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_FLOW_SETPOINT: regs.flow_setpoint <= cfg.data;
        REG_CLOSED_LEVEL:  regs.closed_level  <= cfg.data[PosW-1:0];
        REG_FULL_LEVEL:    regs.full_level    <= cfg.data[PosW-1:0];
        REG_PULSE_LENGTH:  regs.pulse_length  <= cfg.data[CntW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Pipeline control
  assign advance       = !out_valid || out_item.ready;
  assign s1_move       = s1_valid && advance;
  assign in_item.ready = !s1_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_item.ready) begin
      s1_valid <= in_item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_item.valid && in_item.ready) begin
      s1_item.op             <= in_item.op;
      s1_item.measured_flow  <= in_item.measured_flow;
      s1_item.valve_position <= in_item.valve_position;
    end
  end

  pvfc_step u_step (
    .item (s1_item),
    .cfg  (regs),
    .cur  (state),
    .nxt  (state_next)
  );

  // Valve state advances as each item leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (s1_move) begin
      state <= state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_item.valve_mode  <= state_next.mode;
      out_item.drive_open  <= state_next.open_drive;
      out_item.drive_close <= state_next.close_drive;
    end
  end

  assign out_item.valid = out_valid;

endmodule

// ----- hw/rtl/pvfc_step.sv -----
// ----------------------------------------------------------------------------
// pvfc_step: next-state logic of the valve controller
// Applies one command or tick to the current valve state.
// ----------------------------------------------------------------------------
module pvfc_step (
  input  pvfc_pkg::in_item_t     item,
  input  pvfc_pkg::cfg_t         cfg,
  input  pvfc_pkg::valve_state_t cur,
  output pvfc_pkg::valve_state_t nxt
);
  import pvfc_pkg::*;

  logic [FlowW:0] flow_x;
  logic [FlowW:0] sp_x;
  logic           flow_ge_sp;
  logic           flow_gt_sp;
  logic           flow_lt_sp;
  logic           flow_lt_sp_m1;
  logic           flow_gt_sp_p1;
  logic           pos_gt_full;
  logic           pos_lt_closed;
  logic           cnt_zero;

  // Compare one bit wider so setpoint plus or minus one never wraps
  assign flow_x        = {1'b0, item.measured_flow};
  assign sp_x          = {1'b0, cfg.flow_setpoint};
  assign flow_ge_sp    = flow_x >= sp_x;
  assign flow_gt_sp    = flow_x > sp_x;
  assign flow_lt_sp    = flow_x < sp_x;
  assign flow_lt_sp_m1 = (flow_x + 1'b1) < sp_x;
  assign flow_gt_sp_p1 = flow_x > (sp_x + 1'b1);
  assign pos_gt_full   = item.valve_position > cfg.full_level;
  assign pos_lt_closed = item.valve_position < cfg.closed_level;
  assign cnt_zero      = cur.pulse_counter == '0;

  always_comb begin
    nxt = cur;
    unique case (item.op)
      OP_TICK: begin
        unique case (cur.mode)
          MODE_IDLE: begin
          end
          MODE_OPENING: begin
            if (flow_ge_sp || pos_gt_full) begin
              nxt.mode        = MODE_SET;
              nxt.open_drive  = 1'b0;
              nxt.close_drive = 1'b0;
            end
          end
          MODE_CLOSING: begin
            if (pos_lt_closed) begin
              nxt.mode        = MODE_IDLE;
              nxt.open_drive  = 1'b0;
              nxt.close_drive = 1'b0;
            end
          end
          MODE_PCLOSE, MODE_POPEN: begin
            // End the pulse on a setpoint crossing or an expired counter
            nxt.pulse_counter = cur.pulse_counter - 1'b1;
            if (cnt_zero || (cur.mode == MODE_PCLOSE ? flow_lt_sp : flow_gt_sp)) begin
              nxt.mode        = MODE_SET;
              nxt.open_drive  = 1'b0;
              nxt.close_drive = 1'b0;
            end
          end
          MODE_SET: begin
            // Start a pulse unless the valve sits at the matching end stop
            priority if (flow_lt_sp_m1) begin
              if (!pos_gt_full) begin
                nxt.mode          = MODE_POPEN;
                nxt.open_drive    = 1'b1;
                nxt.close_drive   = 1'b0;
                nxt.pulse_counter = cfg.pulse_length;
              end
            end else if (flow_gt_sp_p1) begin
              if (!pos_lt_closed) begin
                nxt.mode          = MODE_PCLOSE;
                nxt.open_drive    = 1'b0;
                nxt.close_drive   = 1'b1;
                nxt.pulse_counter = cfg.pulse_length;
              end
            end else begin
              // Hold inside the dead band
            end
          end
          MODE_ERROR: begin
            nxt.open_drive  = 1'b0;
            nxt.close_drive = 1'b0;
          end
          default: begin
            nxt.mode        = MODE_IDLE;
            nxt.open_drive  = 1'b0;
            nxt.close_drive = 1'b0;
          end
        endcase
      end
      OP_OPEN: begin
        nxt.mode        = MODE_OPENING;
        nxt.open_drive  = 1'b1;
        nxt.close_drive = 1'b0;
      end
      OP_CLOSE: begin
        nxt.mode        = MODE_CLOSING;
        nxt.open_drive  = 1'b0;
        nxt.close_drive = 1'b1;
      end
      OP_IDLE: begin
        nxt.mode        = MODE_IDLE;
        nxt.open_drive  = 1'b0;
        nxt.close_drive = 1'b0;
      end
      OP_ERROR: begin
        nxt.mode        = MODE_ERROR;
        nxt.open_drive  = 1'b0;
        nxt.close_drive = 1'b0;
      end
      default: begin
        // Unknown operation: keep the state, report it unchanged
      end
    endcase
  end

endmodule

// ----- hw/rtl/pvfc_checker.sv -----
// ----------------------------------------------------------------------------
// pvfc_checker: port-level checks for the valve controller
// Watches result drives per mode, drive conflicts, stalls and reset.
// ----------------------------------------------------------------------------
module pvfc_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [pvfc_pkg::ModeW-1:0] valve_mode,
  input logic                   drive_open,
  input logic                   drive_close
);
  import pvfc_pkg::*;

  // Never drive both directions at once
  a_no_conflict: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(drive_open && drive_close))
    else $error("both drives reported on");

  // Resting modes keep both drives off
  a_rest_off: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (valve_mode == MODE_IDLE || valve_mode == MODE_SET ||
                   valve_mode == MODE_ERROR)) |-> (!drive_open && !drive_close))
    else $error("drive on in a resting mode");

  // Opening modes drive the open direction
  a_move_on: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (valve_mode == MODE_OPENING || valve_mode == MODE_POPEN))
      |-> drive_open)
    else $error("open mode without open drive");

  // A stalled result stays valid and unchanged
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(valve_mode) &&
      $stable(drive_open) && $stable(drive_close)))
    else $error("stalled result changed");

  // Nothing leaves right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind pulsed_valve_flow_controller pvfc_checker u_pvfc_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_item.valid),
  .out_ready   (out_item.ready),
  .valve_mode  (out_item.valve_mode),
  .drive_open  (out_item.drive_open),
  .drive_close (out_item.drive_close)
);
